### rtl/cau_pkg.sv
// Package for the complex arithmetic unit: data format, derived widths,
// operation and status codes, and pipeline stage types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;

	localparam int PW  = 2 * DATA_WIDTH;
	localparam int SW  = PW + 1;
	localparam int MW  = PW;
	localparam int NW  = MW + FRAC_BITS + 1;
	localparam int QW  = DATA_WIDTH + FRAC_BITS + 2;
	localparam int DSW = MW + QW;
	localparam int BW  = MW + DATA_WIDTH + 1;
	localparam int UW  = (MW + 1 > QW) ? MW + 1 : QW;

	localparam int IN_W   = ((4 * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
	localparam int IN_PAD = IN_W - 4 * DATA_WIDTH;
	localparam int OUT_PAD = OUT_W - 2 * DATA_WIDTH;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_DZ  = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	typedef logic signed [DATA_WIDTH-1:0] part_t;

	typedef struct packed {
		op_t                       op;
		logic                      dz;
		logic signed [DATA_WIDTH:0] sr;
		logic signed [DATA_WIDTH:0] si;
	} ctl_t;

	typedef struct packed {
		ctl_t                 c;
		logic signed [PW-1:0] p_rr;
		logic signed [PW-1:0] p_ii;
		logic signed [PW-1:0] p_ri;
		logic signed [PW-1:0] p_ir;
		logic signed [PW-1:0] p_br;
		logic signed [PW-1:0] p_bi;
	} prod_t;

	typedef struct packed {
		ctl_t                 c;
		logic signed [SW-1:0] xr;
		logic signed [SW-1:0] xi;
		logic [MW-1:0]        den;
	} sum_t;

	typedef struct packed {
		ctl_t          c;
		logic          neg_r;
		logic          neg_i;
		logic [MW-1:0] mr;
		logic [MW-1:0] mi;
		logic [MW-1:0] den;
	} mag_t;

	typedef struct packed {
		ctl_t          c;
		logic          neg_r;
		logic          neg_i;
		logic          big_r;
		logic          big_i;
		logic [UW-1:0] mul_r;
		logic [UW-1:0] mul_i;
		logic [MW-1:0] den;
		logic [NW-1:0] rr;
		logic [NW-1:0] ri;
		logic [QW-1:0] qr;
		logic [QW-1:0] qi;
	} div_t;

endpackage
`default_nettype wire

### rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: add, subtract, multiply, divide.
// Depends on cau_pkg.
//
// One beat per cycle in and out while the output is not stalled; fully
// pipelined, with most of its stages in the restoring divider that
// resolves one quotient bit per stage. Every operation takes the same path,
// so results leave in input order. A stalled output freezes the whole pipe.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit
	import cau_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire [IN_W-1:0]   s_tdata,  // a_real, a_imag, b_real, b_imag
	input  wire [1:0]        s_tuser,  // op
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [OUT_W-1:0] m_tdata,  // res_real, res_imag
	output logic [1:0]       m_tuser   // status
);

	localparam logic [UW-1:0] HALF   = (FRAC_BITS == 0) ? UW'(0) : (UW'(1) << (FRAC_BITS - 1));
	localparam logic [UW-1:0] MINMAG = UW'(1) << (DATA_WIDTH - 1);
	localparam logic [UW-1:0] MAXMAG = MINMAG - UW'(1);

	logic  en;
	logic  v_s1, v_s2, v_s3, v_s4;
	prod_t p_s1;
	sum_t  x_s2;
	mag_t  m_s3;
	div_t  d_s4;
	logic  div_v_s [QW];
	div_t  div_s   [QW];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: products, add/subtract sums, divide-by-zero flag
	part_t ar, ai, br, bi;
	op_t   op_in;
	prod_t p_nx;
	assign ar    = part_t'(s_tdata[DATA_WIDTH-1:0]);
	assign ai    = part_t'(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
	assign br    = part_t'(s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]);
	assign bi    = part_t'(s_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH]);
	assign op_in = op_t'(s_tuser);

	always_comb begin
		p_nx.c.op = op_in;
		p_nx.c.dz = (op_in == OP_DIV) && (br == '0) && (bi == '0);
		if (op_in == OP_SUB) begin
			p_nx.c.sr = (DATA_WIDTH + 1)'(ar) - (DATA_WIDTH + 1)'(br);
			p_nx.c.si = (DATA_WIDTH + 1)'(ai) - (DATA_WIDTH + 1)'(bi);
		end else begin
			p_nx.c.sr = (DATA_WIDTH + 1)'(ar) + (DATA_WIDTH + 1)'(br);
			p_nx.c.si = (DATA_WIDTH + 1)'(ai) + (DATA_WIDTH + 1)'(bi);
		end
		p_nx.p_rr = PW'(ar) * PW'(br);
		p_nx.p_ii = PW'(ai) * PW'(bi);
		p_nx.p_ri = PW'(ar) * PW'(bi);
		p_nx.p_ir = PW'(ai) * PW'(br);
		p_nx.p_br = PW'(br) * PW'(br);
		p_nx.p_bi = PW'(bi) * PW'(bi);
	end

	// stage 2: sums of products
	sum_t x_nx;
	always_comb begin
		x_nx.c = p_s1.c;
		if (p_s1.c.op == OP_DIV) begin
			x_nx.xr = SW'(p_s1.p_rr) + SW'(p_s1.p_ii);
			x_nx.xi = SW'(p_s1.p_ir) - SW'(p_s1.p_ri);
		end else begin
			x_nx.xr = SW'(p_s1.p_rr) - SW'(p_s1.p_ii);
			x_nx.xi = SW'(p_s1.p_ri) + SW'(p_s1.p_ir);
		end
		x_nx.den = MW'($unsigned(p_s1.p_br)) + MW'($unsigned(p_s1.p_bi));
	end

	// stage 3: sign and magnitude
	mag_t m_nx;
	always_comb begin
		m_nx.c     = x_s2.c;
		m_nx.neg_r = x_s2.xr[SW-1];
		m_nx.neg_i = x_s2.xi[SW-1];
		m_nx.mr    = MW'(x_s2.xr[SW-1] ? -x_s2.xr : x_s2.xr);
		m_nx.mi    = MW'(x_s2.xi[SW-1] ? -x_s2.xi : x_s2.xi);
		m_nx.den   = x_s2.den;
	end

	// stage 4: product rounding, quotient range check, dividend setup
	div_t d_nx;
	always_comb begin
		d_nx.c     = m_s3.c;
		d_nx.neg_r = m_s3.neg_r;
		d_nx.neg_i = m_s3.neg_i;
		d_nx.mul_r = (UW'(m_s3.mr) + HALF) >> FRAC_BITS;
		d_nx.mul_i = (UW'(m_s3.mi) + HALF) >> FRAC_BITS;
		d_nx.big_r = BW'(m_s3.mr) >= (BW'(m_s3.den) << (DATA_WIDTH + 1));
		d_nx.big_i = BW'(m_s3.mi) >= (BW'(m_s3.den) << (DATA_WIDTH + 1));
		d_nx.den   = m_s3.den;
		d_nx.rr    = NW'(m_s3.mr) << (FRAC_BITS + 1);
		d_nx.ri    = NW'(m_s3.mi) << (FRAC_BITS + 1);
		d_nx.qr    = '0;
		d_nx.qi    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p_nx;
			x_s2 <= x_nx;
			m_s3 <= m_nx;
			d_s4 <= d_nx;
		end
	end

	// divider stages: one quotient bit each, most significant first
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		div_t           din, dnx;
		logic           vin;
		logic [DSW-1:0] dsh;

		if (j == 0) begin : g_first
			assign din = d_s4;
			assign vin = v_s4;
		end else begin : g_next
			assign din = div_s[j-1];
			assign vin = div_v_s[j-1];
		end

		assign dsh = DSW'(din.den) << K;

		always_comb begin
			dnx = din;
			if (DSW'(din.rr) >= dsh) begin
				dnx.rr    = din.rr - NW'(dsh);
				dnx.qr[K] = 1'b1;
			end
			if (DSW'(din.ri) >= dsh) begin
				dnx.ri    = din.ri - NW'(dsh);
				dnx.qi[K] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j] <= 1'b0;
			end else if (en) begin
				div_v_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j] <= dnx;
			end
		end
	end

	// output stage: round quotient, saturate, select
	function automatic logic [DATA_WIDTH:0] from_mag(input logic [UW-1:0] m,
			input logic neg, input logic ovf);
		logic [DATA_WIDTH:0] r;
		if (neg) begin
			if (ovf || m > MINMAG) begin
				r = {1'b1, 1'b1, {(DATA_WIDTH - 1){1'b0}}};
			end else begin
				r = {1'b0, DATA_WIDTH'(UW'(0) - m)};
			end
		end else begin
			if (ovf || m > MAXMAG) begin
				r = {1'b1, 1'b0, {(DATA_WIDTH - 1){1'b1}}};
			end else begin
				r = {1'b0, DATA_WIDTH'(m)};
			end
		end
		return r;
	endfunction

	function automatic logic [DATA_WIDTH:0] clamp_sum(input logic signed [DATA_WIDTH:0] s);
		logic [DATA_WIDTH:0] r;
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
			r = {1'b1, s[DATA_WIDTH], {(DATA_WIDTH - 1){~s[DATA_WIDTH]}}};
		end else begin
			r = {1'b0, s[DATA_WIDTH-1:0]};
		end
		return r;
	endfunction

	div_t                last;
	logic                last_v;
	logic [UW-1:0]       qmag_r, qmag_i;
	logic [DATA_WIDTH:0] res_r, res_i;
	part_t               out_r, out_i;
	status_t             st;

	assign last   = div_s[QW-1];
	assign last_v = div_v_s[QW-1];
	assign qmag_r = UW'((QW + 1)'((QW + 1)'(last.qr) + (QW + 1)'(1)) >> 1);
	assign qmag_i = UW'((QW + 1)'((QW + 1)'(last.qi) + (QW + 1)'(1)) >> 1);

	always_comb begin
		unique case (last.c.op)
			OP_ADD, OP_SUB: begin
				res_r = clamp_sum(last.c.sr);
				res_i = clamp_sum(last.c.si);
			end
			OP_MUL: begin
				res_r = from_mag(last.mul_r, last.neg_r, 1'b0);
				res_i = from_mag(last.mul_i, last.neg_i, 1'b0);
			end
			OP_DIV: begin
				res_r = from_mag(qmag_r, last.neg_r, last.big_r);
				res_i = from_mag(qmag_i, last.neg_i, last.big_i);
			end
		endcase
		if (last.c.dz) begin
			out_r = '0;
			out_i = '0;
			st    = ST_DZ;
		end else begin
			out_r = part_t'(res_r[DATA_WIDTH-1:0]);
			out_i = part_t'(res_i[DATA_WIDTH-1:0]);
			st    = (res_r[DATA_WIDTH] || res_i[DATA_WIDTH]) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= last_v;
		end
	end

	generate
		if (OUT_PAD > 0) begin : g_opad
			always_ff @(posedge clk) begin
				if (en) begin
					m_tdata <= {{OUT_PAD{1'b0}}, out_i, out_r};
					m_tuser <= st;
				end
			end
		end else begin : g_onopad
			always_ff @(posedge clk) begin
				if (en) begin
					m_tdata <= {out_i, out_r};
					m_tuser <= st;
				end
			end
		end
	endgenerate

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_DZ) |-> (m_tdata[2*DATA_WIDTH-1:0] == '0))
		else $error("divide by zero beat carries nonzero data");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_SAT) |->
			(m_tdata[DATA_WIDTH-1:DATA_WIDTH-2] == 2'b01) ||
			(m_tdata[DATA_WIDTH-1:DATA_WIDTH-2] == 2'b10) ||
			(m_tdata[2*DATA_WIDTH-1:2*DATA_WIDTH-2] == 2'b01) ||
			(m_tdata[2*DATA_WIDTH-1:2*DATA_WIDTH-2] == 2'b10))
		else $error("saturated beat has no part near a limit");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s4 |=> div_v_s[0])
		else $error("beat lost entering divider");

	a_out_follow: assert property (@(posedge clk) disable iff (!arst_n)
		en && last_v |=> m_tvalid)
		else $error("beat lost at output stage");

endmodule
`default_nettype wire
